[rtl/packed_pixel_to_rgb_decoder_defines.svh]
// Assertion macros for the packed pixel to RGB decoder.
// Used by the modules that carry concurrent checks; expects clk and rst in scope.
`ifndef PACKED_PIXEL_TO_RGB_DECODER_DEFINES_SVH
`define PACKED_PIXEL_TO_RGB_DECODER_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define PPD_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ppd check failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define PPD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ppd check failed");

`endif

[rtl/ppd_pkg.sv]
// Shared types, constants and the Q10 clamp for the packed pixel decoder.
// No dependencies; all other sources but the macro header import it.
`timescale 1ns / 1ps
`default_nettype none

package ppd_pkg;

  localparam int WordW    = 32;
  localparam int ChanW    = 8;
  localparam int CfgIdxW  = 1;
  localparam int CfgDataW = 2;
  // Signed width of the BT.601 sums; the largest magnitude is below 2^20.
  localparam int SumW     = 22;

  // BT.601 coefficients in Q10.
  localparam int CoefY  = 1192;
  localparam int CoefRv = 1634;
  localparam int CoefGv = 833;
  localparam int CoefGu = 400;
  localparam int CoefBu = 2066;
  localparam int LumaOffset   = 16;
  localparam int ChromaOffset = 128;
  localparam int ClampHigh    = 255 * 1024;

  typedef enum logic [1:0] {
    FMT_RGB565 = 2'd0,
    FMT_RGB555 = 2'd1,
    FMT_RGB888 = 2'd2,
    FMT_UYVY   = 2'd3
  } fmt_t;

  typedef enum logic [CfgIdxW-1:0] {
    REG_PIXEL_FORMAT = 1'b0,
    REG_BIG_ENDIAN   = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic [ChanW-1:0] red;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] blue;
  } rgb_t;

  typedef struct packed {
    rgb_t color;
    logic last_of_word;
    logic image_done;
  } pixel_t;

  // Floor of a Q10 sum, saturated to 0..255.
  function automatic logic [ChanW-1:0] clamp_q10(input logic signed [SumW-1:0] s);
    logic [ChanW-1:0] res;
    if (s <= 0) begin
      res = '0;
    end else if (s >= SumW'(ClampHigh)) begin
      res = {ChanW{1'b1}};
    end else begin
      res = s[10 +: ChanW];
    end
    return res;
  endfunction

endpackage

`default_nettype wire

[rtl/ppd_if.sv]
// Valid/ready channel interfaces for the packed pixel decoder: input words
// and output pixels. Depends on ppd_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none

interface ppd_word_if;
  import ppd_pkg::*;
  logic             valid;
  logic             ready;
  logic [WordW-1:0] pixel_word;
  logic             end_of_image;

  modport source (output valid, output pixel_word, output end_of_image, input ready);
  modport sink   (input valid, input pixel_word, input end_of_image, output ready);
endinterface

interface ppd_pixel_if;
  import ppd_pkg::*;
  logic             valid;
  logic             ready;
  logic [ChanW-1:0] red;
  logic [ChanW-1:0] green;
  logic [ChanW-1:0] blue;
  logic             last_of_word;
  logic             image_done;

  modport source (output valid, output red, output green, output blue,
                  output last_of_word, output image_done, input ready);
  modport sink   (input valid, input red, input green, input blue,
                  input last_of_word, input image_done, output ready);
endinterface

`default_nettype wire

[rtl/packed_pixel_to_rgb_decoder.sv]
// Top level of the packed pixel to RGB888 decoder: word register, format
// logic and pixel output register. Depends on ppd_pkg, ppd_if, the two units.
`timescale 1ns / 1ps
`default_nettype none

// Decodes 32-bit packed pixel words into 8-bit red, green and blue pixels.
// The format register selects RGB565 or RGB555 (one pixel from the low
// halfword, channels padded with zeros below), RGB888 (one pixel from bits
// 23:0) or UYVY 4:2:2 (two pixels per word, BT.601 in Q10, floored and
// clamped to 0..255). The big-endian flag swaps bytes of RGB words only:
// the low halfword in the 16-bit modes, the whole word in RGB888. An
// accepted word sits in a word register; each cycle the output register
// can take a pixel, one pixel is decoded from it. RGB words therefore run
// at one word per cycle while the output is not stalled; a UYVY word is
// held for two pixels, since the single converter makes the pixel from
// y0 and then from y1. An accepted word waits in the word register and
// its first pixel is registered into the pixel output register once that
// register can take it. last_of_word marks the final pixel of each word
// and image_done carries end_of_image on that pixel. Configuration must
// only be written while no word is in flight; reset is synchronous and
// clears both valid bits and the phase and selects RGB565, no swap.
module packed_pixel_to_rgb_decoder (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         write_enable,
  input  logic [ppd_pkg::CfgIdxW-1:0]  write_index,
  input  logic [ppd_pkg::CfgDataW-1:0] write_data,
  ppd_word_if.sink                     pixel_in,
  ppd_pixel_if.source                  pixel_out
);
  import ppd_pkg::*;
`include "packed_pixel_to_rgb_decoder_defines.svh"

  // Configuration registers.
  fmt_t pixel_format;
  logic big_endian;

  // Word register. phase is set once the first UYVY pixel has gone out.
  logic             in_valid;
  logic [WordW-1:0] in_word;
  logic             in_eoi;
  logic             phase;

  // Pixel output register.
  logic   out_valid;
  pixel_t out_pix;

  logic   is_uyvy;
  logic   final_pix;
  logic   advance;
  logic   accept;
  rgb_t   rgb_color;
  rgb_t   yuv_color;
  logic [ChanW-1:0] y_sel;
  pixel_t pix_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_format <= FMT_RGB565;
      big_endian   <= 1'b0;
    end else if (write_enable) begin
      case (reg_idx_t'(write_index))
        REG_PIXEL_FORMAT: pixel_format <= fmt_t'(write_data);
        REG_BIG_ENDIAN:   big_endian   <= write_data[0];
        default:          ;
      endcase
    end
  end

  // A word leaves the word register with its final pixel; a UYVY word
  // stays for one more step so the second pixel can be made.
  always_comb begin
    is_uyvy   = (pixel_format == FMT_UYVY);
    final_pix = !is_uyvy || phase;
    advance   = in_valid && (!out_valid || pixel_out.ready);
    pixel_in.ready = !in_valid || (advance && final_pix);
    accept    = pixel_in.valid && pixel_in.ready;
  end

  ppd_rgb_unpack u_rgb_unpack (
    .pixel_word   (in_word),
    .pixel_format (pixel_format),
    .big_endian   (big_endian),
    .color        (rgb_color)
  );

  assign y_sel = phase ? in_word[31:24] : in_word[15:8];

  ppd_yuv_pixel u_yuv_pixel (
    .y     (y_sel),
    .u     (in_word[7:0]),
    .v     (in_word[23:16]),
    .color (yuv_color)
  );

  always_comb begin
    pix_next.color        = is_uyvy ? yuv_color : rgb_color;
    pix_next.last_of_word = final_pix;
    pix_next.image_done   = final_pix && in_eoi;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      phase    <= 1'b0;
    end else begin
      if (accept) begin
        in_valid <= 1'b1;
      end else if (advance && final_pix) begin
        in_valid <= 1'b0;
      end
      if (advance) begin
        phase <= !final_pix;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_word <= pixel_in.pixel_word;
      in_eoi  <= pixel_in.end_of_image;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (pixel_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_pix <= pix_next;
    end
  end

  assign pixel_out.valid        = out_valid;
  assign pixel_out.red          = out_pix.color.red;
  assign pixel_out.green        = out_pix.color.green;
  assign pixel_out.blue         = out_pix.color.blue;
  assign pixel_out.last_of_word = out_pix.last_of_word;
  assign pixel_out.image_done   = out_pix.image_done;

  // The first UYVY pixel must leave the word in place for the second.
  `PPD_ASSERT_NEXT(a_first_keeps_word, advance && !final_pix, in_valid && phase)
  // An accepted word always lands in the word register.
  `PPD_ASSERT_NEXT(a_accept_loads, accept, in_valid)
  // The second-pixel phase only exists while a word is held.
  `PPD_ASSERT_IMPL(a_phase_held, phase, in_valid)
  // End of image can only ride on the final pixel of a word.
  `PPD_ASSERT_IMPL(a_done_on_last, out_valid && out_pix.image_done, out_pix.last_of_word)

endmodule

`default_nettype wire

[rtl/ppd_rgb_unpack.sv]
// Unpacks one RGB565, RGB555 or RGB888 pixel, with optional byte swap.
// Depends on ppd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ppd_rgb_unpack (
  input  logic [ppd_pkg::WordW-1:0] pixel_word,
  input  ppd_pkg::fmt_t             pixel_format,
  input  logic                      big_endian,
  output ppd_pkg::rgb_t             color
);
  import ppd_pkg::*;

  logic [WordW-1:0] word_swapped;
  logic [15:0]      half;

  always_comb begin
    word_swapped = big_endian ?
                   {pixel_word[7:0], pixel_word[15:8], pixel_word[23:16], pixel_word[31:24]} :
                   pixel_word;
    half = big_endian ? {pixel_word[7:0], pixel_word[15:8]} : pixel_word[15:0];
    case (pixel_format)
      FMT_RGB565: begin
        color.red   = {half[15:11], 3'b000};
        color.green = {half[10:5], 2'b00};
        color.blue  = {half[4:0], 3'b000};
      end
      FMT_RGB555: begin
        color.red   = {half[14:10], 3'b000};
        color.green = {half[9:5], 3'b000};
        color.blue  = {half[4:0], 3'b000};
      end
      FMT_RGB888: begin
        color.red   = word_swapped[23:16];
        color.green = word_swapped[15:8];
        color.blue  = word_swapped[7:0];
      end
      default: begin
        color = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

[rtl/ppd_yuv_pixel.sv]
// Converts one luma sample and a shared chroma pair to RGB888 with BT.601 in Q10.
// Depends on ppd_pkg for the coefficients and the clamp function.
`timescale 1ns / 1ps
`default_nettype none

module ppd_yuv_pixel (
  input  logic [ppd_pkg::ChanW-1:0] y,
  input  logic [ppd_pkg::ChanW-1:0] u,
  input  logic [ppd_pkg::ChanW-1:0] v,
  output ppd_pkg::rgb_t             color
);
  import ppd_pkg::*;

  logic signed [SumW-1:0] y_c;
  logic signed [SumW-1:0] u_c;
  logic signed [SumW-1:0] v_c;
  logic signed [SumW-1:0] y_term;
  logic signed [SumW-1:0] sum_r;
  logic signed [SumW-1:0] sum_g;
  logic signed [SumW-1:0] sum_b;

  always_comb begin
    y_c = $signed({{(SumW-ChanW){1'b0}}, y}) - SumW'(LumaOffset);
    u_c = $signed({{(SumW-ChanW){1'b0}}, u}) - SumW'(ChromaOffset);
    v_c = $signed({{(SumW-ChanW){1'b0}}, v}) - SumW'(ChromaOffset);
    y_term = y_c * $signed(SumW'(CoefY));
    sum_r  = y_term + v_c * $signed(SumW'(CoefRv));
    sum_g  = y_term - v_c * $signed(SumW'(CoefGv)) - u_c * $signed(SumW'(CoefGu));
    sum_b  = y_term + u_c * $signed(SumW'(CoefBu));
    color.red   = clamp_q10(sum_r);
    color.green = clamp_q10(sum_g);
    color.blue  = clamp_q10(sum_b);
  end

endmodule

`default_nettype wire

[tb/packed_pixel_to_rgb_decoder_checker.sv]
// Scoreboard for the packed pixel decoder: tracks the register writes, predicts
// the pixels of every accepted word and compares them with the output channel.
// Depends on ppd_pkg and the channel interfaces in ppd_if.
`timescale 1ns / 1ps

module packed_pixel_to_rgb_decoder_checker
  import ppd_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                write_enable,
  input  logic [CfgIdxW-1:0]  write_index,
  input  logic [CfgDataW-1:0] write_data,
  ppd_word_if                 word_ch,
  ppd_pixel_if                pix_ch,
  output int                  pixels_owed,
  output int                  error_count
);

  fmt_t   cfg_format;
  logic   cfg_swap;
  pixel_t expected_pixels[$];
  int     errors;

  initial begin
    cfg_format  = FMT_RGB565;
    cfg_swap    = 1'b0;
    errors      = 0;
    pixels_owed = 0;
    error_count = 0;
  end

  // Floor of a Q10 sum, saturated to the 8-bit channel range.
  function automatic logic [ChanW-1:0] q10_saturate(input int sum);
    if (sum <= 0) return '0;
    if (sum >= 255 * 1024) return 8'hFF;
    return sum[17:10];
  endfunction

  function automatic rgb_t yuv_to_rgb(input int y, input int u, input int v);
    int   luma;
    int   cb;
    int   cr;
    rgb_t c;
    luma    = (y - LumaOffset) * CoefY;
    cb      = u - ChromaOffset;
    cr      = v - ChromaOffset;
    c.red   = q10_saturate(luma + CoefRv * cr);
    c.green = q10_saturate(luma - CoefGv * cr - CoefGu * cb);
    c.blue  = q10_saturate(luma + CoefBu * cb);
    return c;
  endfunction

  function automatic void queue_pixels(input logic [WordW-1:0] w, input logic eoi);
    logic [WordW-1:0] p;
    pixel_t           px;
    if (cfg_format == FMT_UYVY) begin
      // Both pixels share the chroma pair; the byte order flag has no effect here.
      px.color        = yuv_to_rgb(w[15:8], w[7:0], w[23:16]);
      px.last_of_word = 1'b0;
      px.image_done   = 1'b0;
      expected_pixels.push_back(px);
      px.color        = yuv_to_rgb(w[31:24], w[7:0], w[23:16]);
    end else if (cfg_format == FMT_RGB888) begin
      p        = cfg_swap ? {w[7:0], w[15:8], w[23:16], w[31:24]} : w;
      px.color = {p[23:16], p[15:8], p[7:0]};
    end else begin
      p = {16'h0000, cfg_swap ? {w[7:0], w[15:8]} : w[15:0]};
      if (cfg_format == FMT_RGB565) begin
        px.color = {p[15:11], 3'b000, p[10:5], 2'b00, p[4:0], 3'b000};
      end else begin
        px.color = {p[14:10], 3'b000, p[9:5], 3'b000, p[4:0], 3'b000};
      end
    end
    px.last_of_word = 1'b1;
    px.image_done   = eoi;
    expected_pixels.push_back(px);
  endfunction

  always @(posedge clk) begin
    pixel_t got;
    pixel_t want;
    if (rst) begin
      cfg_format = FMT_RGB565;
      cfg_swap   = 1'b0;
      expected_pixels.delete();
    end else begin
      if (pix_ch.valid && pix_ch.ready) begin
        got = {pix_ch.red, pix_ch.green, pix_ch.blue, pix_ch.last_of_word,
               pix_ch.image_done};
        if (expected_pixels.size() == 0) begin
          errors++;
          if (errors <= 10) begin
            $display("%0t: unexpected pixel r=%02h g=%02h b=%02h last=%0b done=%0b",
                     $realtime, got.color.red, got.color.green, got.color.blue,
                     got.last_of_word, got.image_done);
          end
        end else begin
          want = expected_pixels.pop_front();
          if (got.color.red !== want.color.red || got.color.green !== want.color.green ||
              got.color.blue !== want.color.blue ||
              got.last_of_word !== want.last_of_word ||
              got.image_done !== want.image_done) begin
            errors++;
            if (errors <= 10) begin
              $display("%0t: pixel mismatch, expected r=%02h g=%02h b=%02h last=%0b done=%0b",
                       $realtime, want.color.red, want.color.green, want.color.blue,
                       want.last_of_word, want.image_done);
              $display("%0t:                 actual   r=%02h g=%02h b=%02h last=%0b done=%0b",
                       $realtime, got.color.red, got.color.green, got.color.blue,
                       got.last_of_word, got.image_done);
            end
          end
        end
      end
      if (word_ch.valid && word_ch.ready) begin
        queue_pixels(word_ch.pixel_word, word_ch.end_of_image);
      end
      if (write_enable) begin
        if (write_index == REG_PIXEL_FORMAT) begin
          cfg_format = fmt_t'(write_data);
        end else if (write_index == REG_BIG_ENDIAN) begin
          cfg_swap = write_data[0];
        end
      end
    end
    pixels_owed <= expected_pixels.size();
    error_count <= errors;
  end

endmodule

[tb/tb_packed_pixel_to_rgb_decoder.sv]
// Top of the packed pixel decoder testbench: clock, reset, register writes,
// word stimulus and pixel back-pressure. Depends on ppd_pkg, ppd_if, the
// decoder itself and packed_pixel_to_rgb_decoder_checker.
`timescale 1ns / 1ps

module tb_packed_pixel_to_rgb_decoder;
  import ppd_pkg::*;

  // The slowest legal run is at most 888 words, each with a random gap and
  // two pixels that may each wait out a long stall, plus the long hold-off
  // and the drain between phases, so this limit leaves a wide margin.
  localparam int CycleLimit  = 600000;
  localparam int RandomWords = 800;
  localparam int HoldCycles  = 300;

  logic                clk;
  logic                rst;
  logic                write_enable;
  logic [CfgIdxW-1:0]  write_index;
  logic [CfgDataW-1:0] write_data;

  int   pixels_owed;
  int   error_count;
  // Set by the stimulus to ask the pixel sink for one long hold-off; the
  // sink clears it once the hold-off is over.
  logic hold_output;

  ppd_word_if  word_ch ();
  ppd_pixel_if pix_ch ();

  packed_pixel_to_rgb_decoder DUT (
    .clk          (clk),
    .rst          (rst),
    .write_enable (write_enable),
    .write_index  (write_index),
    .write_data   (write_data),
    .pixel_in     (word_ch),
    .pixel_out    (pix_ch)
  );

  packed_pixel_to_rgb_decoder_checker scoreboard (
    .clk          (clk),
    .rst          (rst),
    .write_enable (write_enable),
    .write_index  (write_index),
    .write_data   (write_data),
    .word_ch      (word_ch),
    .pix_ch       (pix_ch),
    .pixels_owed  (pixels_owed),
    .error_count  (error_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Every input is known from time zero. All later changes are nonblocking
  // assignments made right after a rising edge, so the design and the
  // scoreboard always sample the values from before that edge.
  initial begin
    rst                  = 1'b1;
    write_enable         = 1'b0;
    write_index          = REG_PIXEL_FORMAT;
    write_data           = '0;
    word_ch.valid        = 1'b0;
    word_ch.pixel_word   = '0;
    word_ch.end_of_image = 1'b0;
    pix_ch.ready         = 1'b0;
    hold_output          = 1'b0;
  end

  // Watchdog: a run that hangs or loses a pixel ends here.
  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CycleLimit) begin
      @(posedge clk);
      cycles++;
    end
    $display("simulation failed");
    $finish;
  end

  // Pixel sink. Most of the time ready toggles at random, with short stalls,
  // a few long ones and some long stretches of steady ready. On request it
  // holds ready low for a long hold-off, which lets the decoder fill up and
  // push back on the word channel. A request cuts the current random
  // stretch short so the hold-off starts right away.
  initial begin : pixel_sink
    int n;
    int pick;
    while (rst) @(posedge clk);
    forever begin
      if (hold_output) begin
        pix_ch.ready <= 1'b0;
        for (n = 0; n < HoldCycles; n++) @(posedge clk);
        hold_output = 1'b0;
      end else begin
        pick = $urandom_range(99);
        if (pick < 55) begin
          pix_ch.ready <= 1'b1;
          n = $urandom_range(1, 12);
        end else if (pick < 65) begin
          pix_ch.ready <= 1'b1;
          n = $urandom_range(60, 200);
        end else if (pick < 95) begin
          pix_ch.ready <= 1'b0;
          n = $urandom_range(1, 4);
        end else begin
          pix_ch.ready <= 1'b0;
          n = $urandom_range(15, 40);
        end
        while (n > 0) begin
          @(posedge clk);
          n--;
          if (hold_output) n = 0;
        end
      end
    end
  end

  // Writes the format register, then the byte order register. The spare high
  // bit of the write data is random on the byte order write; only bit 0 counts.
  task automatic set_config(input fmt_t fmt, input logic swap);
    write_enable <= 1'b1;
    write_index  <= REG_PIXEL_FORMAT;
    write_data   <= fmt;
    @(posedge clk);
    write_index  <= REG_BIG_ENDIAN;
    write_data   <= {1'($urandom), swap};
    @(posedge clk);
    write_enable <= 1'b0;
  endtask

  // Offers one word and returns at the edge where it is taken. Valid stays
  // high, so back-to-back words need no extra assignment in between.
  task automatic send_word(input logic [WordW-1:0] w, input logic eoi);
    word_ch.valid        <= 1'b1;
    word_ch.pixel_word   <= w;
    word_ch.end_of_image <= eoi;
    @(posedge clk);
    while (!word_ch.ready) @(posedge clk);
  endtask

  // Random idle time on the word side: usually none, often a few cycles,
  // now and then a long pause.
  task automatic word_gap();
    int pick;
    int n;
    pick = $urandom_range(99);
    if (pick < 60) begin
      n = 0;
    end else if (pick < 92) begin
      n = $urandom_range(1, 3);
    end else begin
      n = $urandom_range(8, 40);
    end
    if (n > 0) begin
      word_ch.valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // Stops offering words and waits until every predicted pixel has been
  // seen. An edge first lets the scoreboard count the last accepted word,
  // and a final wait comes before the next register write.
  task automatic wait_idle();
    word_ch.valid <= 1'b0;
    @(posedge clk);
    while (pixels_owed != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  // Random byte, weighted toward the values that hit the YUV clamps and
  // the black and white levels.
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(9))
      0:       return 8'h00;
      1:       return 8'hFF;
      2:       return 8'h10;
      3:       return 8'hEB;
      4:       return 8'h80;
      default: return 8'($urandom);
    endcase
  endfunction

  initial begin : stimulus
    int   phase;
    int   words_sent;
    int   count;
    int   remaining;
    int   k;
    logic gapless;
    logic eoi;
    fmt_t fmt;
    logic swap;

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed words. The first group relies on the reset value of the
    // registers, which is RGB565 with no byte swap.
    send_word(32'h0000_0000, 1'b0);
    send_word(32'hFFFF_FFFF, 1'b1);
    send_word(32'hABCD_F800, 1'b0);   // red only, high halfword ignored
    send_word(32'h0000_07E0, 1'b0);   // green only
    send_word(32'h0000_001F, 1'b1);   // blue only
    wait_idle();

    // RGB565 with the low halfword byte swapped.
    set_config(FMT_RGB565, 1'b1);
    send_word(32'h0000_00F8, 1'b0);
    send_word(32'h1234_E007, 1'b1);
    wait_idle();

    // RGB555: bit 15 has no effect.
    set_config(FMT_RGB555, 1'b0);
    send_word(32'h0000_8000, 1'b0);
    send_word(32'h0000_7FFF, 1'b1);
    wait_idle();

    // RGB888: the top byte is ignored, and with the swap all four bytes
    // are reversed before bits 23:0 are taken.
    set_config(FMT_RGB888, 1'b0);
    send_word(32'hFF00_0000, 1'b0);
    send_word(32'h0012_3456, 1'b1);
    wait_idle();
    set_config(FMT_RGB888, 1'b1);
    send_word(32'h5634_12AB, 1'b1);
    wait_idle();

    // UYVY: black, white, all zeros, all ones and the chroma extremes, which
    // together drive every channel into both clamps.
    set_config(FMT_UYVY, 1'b0);
    send_word(32'h1080_1080, 1'b0);
    send_word(32'hEB80_EB80, 1'b0);
    send_word(32'h0000_0000, 1'b0);
    send_word(32'hFFFF_FFFF, 1'b1);
    send_word(32'hFF00_FF00, 1'b0);
    send_word(32'h00FF_00FF, 1'b1);
    wait_idle();

    // UYVY ignores the byte order flag.
    set_config(FMT_UYVY, 1'b1);
    send_word(32'h1234_5678, 1'b1);
    wait_idle();

    // Random phases. The first eight cover every format with and without
    // the swap; later ones pick a setting at random. Words come in images
    // of random length with end_of_image on the last word, and a small
    // share of words get a flipped end_of_image to break the framing.
    // Every phase ends with the sender idle until all pixels are back.
    phase      = 0;
    words_sent = 0;
    while (words_sent < RandomWords) begin
      if (phase < 8) begin
        fmt  = fmt_t'(phase[1:0]);
        swap = phase[2];
      end else begin
        fmt  = fmt_t'($urandom_range(3));
        swap = 1'($urandom);
      end
      set_config(fmt, swap);
      gapless = ($urandom_range(3) == 0);
      count   = $urandom_range(40, 70);
      // In two phases, one of them UYVY, the sink stops for a long time
      // while words keep coming without gaps, so the input stalls.
      if (phase == 3 || phase == 9) begin
        hold_output = 1'b1;
        gapless     = 1'b1;
      end
      remaining = 0;
      for (k = 0; k < count; k++) begin
        if (remaining == 0) remaining = $urandom_range(1, 12);
        remaining--;
        eoi = (remaining == 0);
        if ($urandom_range(19) == 0) eoi = ~eoi;
        send_word({pick_byte(), pick_byte(), pick_byte(), pick_byte()}, eoi);
        words_sent++;
        if (!gapless) word_gap();
      end
      wait_idle();
      phase++;
    end

    // Drain: nothing is owed any more; give a stray pixel time to show up.
    repeat (20) @(posedge clk);
    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+rtl
rtl/ppd_pkg.sv
rtl/ppd_if.sv
rtl/ppd_rgb_unpack.sv
rtl/ppd_yuv_pixel.sv
rtl/packed_pixel_to_rgb_decoder.sv
tb/packed_pixel_to_rgb_decoder_checker.sv
tb/tb_packed_pixel_to_rgb_decoder.sv
